/* hw/rtl/shell_command_line_tokenizer_top_assert.svh */
// ----------------------------------------------------------------------------
// Tokenizer assertion macros
// Shared concurrent assertion forms used by the tokenizer top level.
// ----------------------------------------------------------------------------
`ifndef SHELL_COMMAND_LINE_TOKENIZER_TOP_ASSERT_SVH
`define SHELL_COMMAND_LINE_TOKENIZER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define TKZ_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tokenizer check failed");

// Next-cycle implication, disabled while reset is low.
`define TKZ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tokenizer check failed");

`endif

/* hw/rtl/tkz_pkg.sv */
// ----------------------------------------------------------------------------
// Tokenizer package
// Lexer state codes, result kinds, character constants and helpers.
// ----------------------------------------------------------------------------
package tkz_pkg;

    localparam int MAX_RES = 3;

    // Lexer states, one-hot.
    typedef enum logic [9:0] {
        LX_TEXT    = 10'b00_0000_0001,
        LX_ESC     = 10'b00_0000_0010,
        LX_SQ      = 10'b00_0000_0100,
        LX_DQ      = 10'b00_0000_1000,
        LX_VAR     = 10'b00_0001_0000,
        LX_VNAME   = 10'b00_0010_0000,
        LX_VBRACE  = 10'b00_0100_0000,
        LX_QVAR    = 10'b00_1000_0000,
        LX_QVNAME  = 10'b01_0000_0000,
        LX_QVBRACE = 10'b10_0000_0000
    } t_lex;

    typedef enum logic [2:0] {
        K_LIT  = 3'd0,
        K_VBYTE = 3'd1,
        K_VEND = 3'd2,
        K_AEND = 3'd3,
        K_DONE = 3'd4,
        K_MORE = 3'd5
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] byte_out;
        logic [9:0] arg_total;
    } t_result;

    typedef t_result [MAX_RES-1:0] t_res_vec;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DIG_0  = 8'h30;
    localparam logic [7:0] CH_DIG_9  = 8'h39;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    function automatic logic is_blank(input logic [7:0] c);
        return c inside {CH_SPACE, CH_TAB, CH_LF, CH_CR};
    endfunction

    function automatic logic is_name_char(input logic [7:0] c);
        return c inside {[CH_LO_A:CH_LO_Z], [CH_UP_A:CH_UP_Z], [CH_DIG_0:CH_DIG_9], CH_UNDER};
    endfunction

    function automatic logic in_name(input t_lex s);
        return s inside {LX_VNAME, LX_VBRACE, LX_QVNAME, LX_QVBRACE};
    endfunction

    function automatic t_result mk_result(input t_kind k, input logic [7:0] b,
                                          input logic [9:0] total);
        t_result r;
        r.kind      = k;
        r.byte_out  = b;
        r.arg_total = total;
        return r;
    endfunction

endpackage

/* hw/rtl/tkz_step.sv */
// ----------------------------------------------------------------------------
// Tokenizer step logic
// Computes the next lexer state, argument flags and the result list for one
// transaction from the current state.
// ----------------------------------------------------------------------------
module tkz_step #(
    parameter int MAX_ARGS = 512,
    parameter int CNT_W    = 10
) (
    input  tkz_pkg::t_lex     i_lex,
    input  logic              i_arg_open,
    input  logic [CNT_W-1:0]  i_count,
    input  logic              i_cont,
    input  logic              i_cmd,
    input  logic [7:0]        i_ch,
    output tkz_pkg::t_lex     o_lex,
    output logic              o_arg_open,
    output logic [CNT_W-1:0]  o_count,
    output tkz_pkg::t_res_vec o_res,
    output logic [1:0]        o_cnt
);

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ARGS);

    function automatic logic [9:0] to_total(input logic [CNT_W-1:0] c);
        logic [CNT_W+9:0] wide;
        wide = {10'd0, c};
        return wide[9:0];
    endfunction

    tkz_pkg::t_lex w_nx;
    logic [7:0]    w_keep;
    logic          w_pending;

    // Character-level transition of the lexer.
    always_comb begin
        w_keep = i_ch;
        w_nx   = i_lex;
        case (i_lex)
            tkz_pkg::LX_ESC: begin
                w_nx = tkz_pkg::LX_TEXT;
            end
            tkz_pkg::LX_SQ: begin
                if (i_ch == tkz_pkg::CH_SQUOTE) begin
                    w_keep = tkz_pkg::CH_NUL;
                    w_nx   = tkz_pkg::LX_TEXT;
                end
            end
            tkz_pkg::LX_DQ: begin
                if (i_ch == tkz_pkg::CH_DQUOTE) begin
                    w_keep = tkz_pkg::CH_NUL;
                    w_nx   = tkz_pkg::LX_TEXT;
                end else if (i_ch == tkz_pkg::CH_DOLLAR) begin
                    w_keep = tkz_pkg::CH_NUL;
                    w_nx   = tkz_pkg::LX_QVAR;
                end
            end
            tkz_pkg::LX_VAR: begin
                if (i_ch == tkz_pkg::CH_LBRACE) begin
                    w_keep = tkz_pkg::CH_NUL;
                    w_nx   = tkz_pkg::LX_VBRACE;
                end else begin
                    w_nx = tkz_pkg::LX_VNAME;
                end
            end
            tkz_pkg::LX_VNAME: begin
                w_nx = tkz_pkg::is_name_char(i_ch) ? tkz_pkg::LX_VNAME : tkz_pkg::LX_TEXT;
            end
            tkz_pkg::LX_VBRACE: begin
                if (i_ch == tkz_pkg::CH_RBRACE) begin
                    w_keep = tkz_pkg::CH_NUL;
                    w_nx   = tkz_pkg::LX_TEXT;
                end
            end
            tkz_pkg::LX_QVAR: begin
                if (i_ch == tkz_pkg::CH_LBRACE) begin
                    w_keep = tkz_pkg::CH_NUL;
                    w_nx   = tkz_pkg::LX_QVBRACE;
                end else begin
                    w_nx = tkz_pkg::LX_QVNAME;
                end
            end
            tkz_pkg::LX_QVNAME: begin
                if (i_ch == tkz_pkg::CH_DQUOTE) begin
                    w_keep = tkz_pkg::CH_NUL;
                    w_nx   = tkz_pkg::LX_TEXT;
                end else if (!tkz_pkg::is_name_char(i_ch)) begin
                    w_nx = tkz_pkg::LX_DQ;
                end
            end
            tkz_pkg::LX_QVBRACE: begin
                if (i_ch == tkz_pkg::CH_RBRACE) begin
                    w_keep = tkz_pkg::CH_NUL;
                    w_nx   = tkz_pkg::LX_DQ;
                end
            end
            default: begin
                w_nx = tkz_pkg::LX_TEXT;
                if (i_ch == tkz_pkg::CH_SQUOTE) begin
                    w_keep = tkz_pkg::CH_NUL;
                    w_nx   = tkz_pkg::LX_SQ;
                end else if (i_ch == tkz_pkg::CH_DQUOTE) begin
                    w_keep = tkz_pkg::CH_NUL;
                    w_nx   = tkz_pkg::LX_DQ;
                end else if (i_ch == tkz_pkg::CH_DOLLAR) begin
                    w_keep = tkz_pkg::CH_NUL;
                    w_nx   = tkz_pkg::LX_VAR;
                end else if (i_ch == tkz_pkg::CH_BSLASH) begin
                    w_keep = tkz_pkg::CH_NUL;
                    w_nx   = tkz_pkg::LX_ESC;
                end
            end
        endcase
    end

    // An unfinished quote, escape or bare dollar sign at line end.
    assign w_pending = i_lex inside {tkz_pkg::LX_ESC, tkz_pkg::LX_SQ, tkz_pkg::LX_DQ,
                                     tkz_pkg::LX_VAR, tkz_pkg::LX_QVAR};

    // Results are appended in order; at most three per transaction.
    always_comb begin
        o_res      = '0;
        o_cnt      = 2'd0;
        o_lex      = i_lex;
        o_arg_open = i_arg_open;
        o_count    = i_count;
        if (i_cmd) begin
            if (w_pending && i_cont) begin
                o_res[0] = tkz_pkg::mk_result(tkz_pkg::K_MORE, tkz_pkg::CH_NUL,
                                              to_total(o_count));
                o_cnt    = 2'd1;
            end else begin
                if (tkz_pkg::in_name(i_lex)) begin
                    o_arg_open   = 1'b1;
                    o_res[o_cnt] = tkz_pkg::mk_result(tkz_pkg::K_VEND, tkz_pkg::CH_NUL,
                                                      to_total(o_count));
                    o_cnt        = o_cnt + 2'd1;
                end
                if (o_arg_open) begin
                    o_arg_open = 1'b0;
                    if (o_count < MAX_CNT) begin
                        o_count = o_count + CNT_W'(1);
                    end
                    o_res[o_cnt] = tkz_pkg::mk_result(tkz_pkg::K_AEND, tkz_pkg::CH_NUL,
                                                      to_total(o_count));
                    o_cnt        = o_cnt + 2'd1;
                end
                o_res[o_cnt] = tkz_pkg::mk_result(tkz_pkg::K_DONE, tkz_pkg::CH_NUL,
                                                  to_total(o_count));
                o_cnt        = o_cnt + 2'd1;
                o_lex        = tkz_pkg::LX_TEXT;
                o_arg_open   = 1'b0;
                o_count      = '0;
            end
        end else if (i_ch != tkz_pkg::CH_NUL) begin
            if (tkz_pkg::in_name(i_lex) && !tkz_pkg::in_name(w_nx)) begin
                o_arg_open   = 1'b1;
                o_res[o_cnt] = tkz_pkg::mk_result(tkz_pkg::K_VEND, tkz_pkg::CH_NUL,
                                                  to_total(o_count));
                o_cnt        = o_cnt + 2'd1;
            end
            if (tkz_pkg::in_name(w_nx)) begin
                if (w_keep != tkz_pkg::CH_NUL) begin
                    o_res[o_cnt] = tkz_pkg::mk_result(tkz_pkg::K_VBYTE, w_keep,
                                                      to_total(o_count));
                    o_cnt        = o_cnt + 2'd1;
                end
            end else if (w_nx == tkz_pkg::LX_TEXT && i_lex != tkz_pkg::LX_ESC &&
                         tkz_pkg::is_blank(w_keep)) begin
                if (o_arg_open) begin
                    o_arg_open = 1'b0;
                    if (o_count < MAX_CNT) begin
                        o_count = o_count + CNT_W'(1);
                    end
                    o_res[o_cnt] = tkz_pkg::mk_result(tkz_pkg::K_AEND, tkz_pkg::CH_NUL,
                                                      to_total(o_count));
                    o_cnt        = o_cnt + 2'd1;
                end
            end else if (w_keep != tkz_pkg::CH_NUL) begin
                o_arg_open   = 1'b1;
                o_res[o_cnt] = tkz_pkg::mk_result(tkz_pkg::K_LIT, w_keep,
                                                  to_total(o_count));
                o_cnt        = o_cnt + 2'd1;
            end
            o_lex = w_nx;
        end
    end

endmodule

/* hw/rtl/tkz_outq.sv */
// ----------------------------------------------------------------------------
// Tokenizer result register
// Holds the results of one transaction and presents them one per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module tkz_outq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  tkz_pkg::t_res_vec i_res,
    input  logic [1:0]        i_cnt,
    input  logic              i_ready,
    output logic              o_free,
    output logic              o_valid,
    output tkz_pkg::t_result  o_result,
    output logic              o_last
);

    logic              r_valid;
    logic [1:0]        r_idx;
    logic [1:0]        r_cnt;
    tkz_pkg::t_res_vec r_res;

    assign o_last   = (r_idx == r_cnt - 2'd1);
    assign o_valid  = r_valid;
    assign o_result = r_res[r_idx];
    assign o_free   = !r_valid || (i_ready && o_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
            r_cnt   <= 2'd1;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= 2'd0;
            r_cnt   <= i_cnt;
        end else if (r_valid && i_ready) begin
            if (o_last) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

/* hw/rtl/shell_command_line_tokenizer_top.sv */
// ----------------------------------------------------------------------------
// Shell command-line tokenizer
// Lexes command-line bytes with quotes, escapes and variable references.
// ----------------------------------------------------------------------------
// Usage: each input transaction on the s_axis side carries one byte (tuser 0)
// or an end-of-line mark (tuser 1). Each produces zero to three result
// transactions on the m_axis side: literal bytes, variable-name bytes,
// variable-end and argument-end marks, command done, or a request for more
// input. tlast marks the final result caused by one input transaction.
// An input transaction is captured in an input register; the lexer step logic
// computes its results from there, and they are loaded into the result
// register once it is free, from which the first result is presented.
// Throughput is one input transaction per cycle while the receiver is ready
// and each causes at most one result; a transaction with more results holds
// the result register until all are taken, which then sets the rate. Zero
// bytes cause no result and pass without touching the result register.
// Reset returns the lexer to plain text, clears the argument count and sets
// continuation on. When the receiver stalls, results hold in the result
// register, the input register fills and then s_axis_tready drops.
// ----------------------------------------------------------------------------
module shell_command_line_tokenizer_top #(
    parameter int MAX_ARGS = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: continuation_enabled.
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] ch
    input  logic        s_axis_tuser,   // [0] cmd
    // Output stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] byte_out, [17:8] arg_total, rest zero
    output logic [2:0]  m_axis_tuser,   // [2:0] kind
    output logic        m_axis_tlast
);

    localparam int CNT_W = $clog2(MAX_ARGS + 1);

    // Input register.
    logic       r_in_valid;
    logic       r_in_cmd;
    logic [7:0] r_in_ch;

    // Lexer state and configuration.
    tkz_pkg::t_lex    r_lex;
    logic             r_arg_open;
    logic [CNT_W-1:0] r_count;
    logic             r_cont;

    tkz_pkg::t_lex     n_lex;
    logic              n_arg_open;
    logic [CNT_W-1:0]  n_count;
    tkz_pkg::t_res_vec w_res;
    logic [1:0]        w_cnt;
    logic              w_free;
    logic              w_adv;
    logic              w_load;
    tkz_pkg::t_result  w_out;

    // The held transaction advances once its results fit in the result
    // register; a transaction without results advances at once.
    assign w_adv         = r_in_valid && (w_cnt == 2'd0 || w_free);
    assign w_load        = r_in_valid && w_cnt != 2'd0 && w_free;
    assign s_axis_tready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_cmd <= s_axis_tuser;
            r_in_ch  <= s_axis_tdata;
        end
    end

    // State advances together with the transaction that changes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lex      <= tkz_pkg::LX_TEXT;
            r_arg_open <= 1'b0;
            r_count    <= '0;
        end else if (w_adv) begin
            r_lex      <= n_lex;
            r_arg_open <= n_arg_open;
            r_count    <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cont <= 1'b1;
        end else if (i_cfg_we) begin
            r_cont <= i_cfg_wdata;
        end
    end

    tkz_step #(
        .MAX_ARGS (MAX_ARGS),
        .CNT_W    (CNT_W)
    ) u_step (
        .i_lex      (r_lex),
        .i_arg_open (r_arg_open),
        .i_count    (r_count),
        .i_cont     (r_cont),
        .i_cmd      (r_in_cmd),
        .i_ch       (r_in_ch),
        .o_lex      (n_lex),
        .o_arg_open (n_arg_open),
        .o_count    (n_count),
        .o_res      (w_res),
        .o_cnt      (w_cnt)
    );

    tkz_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_load),
        .i_res    (w_res),
        .i_cnt    (w_cnt),
        .i_ready  (m_axis_tready),
        .o_free   (w_free),
        .o_valid  (m_axis_tvalid),
        .o_result (w_out),
        .o_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {6'd0, w_out.arg_total, w_out.byte_out};
    assign m_axis_tuser = w_out.kind;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
`include "shell_command_line_tokenizer_top_assert.svh"

    // A taken result that is not the final one is followed by another.
    `TKZ_ASSERT_NEXT(a_run_continues, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid)

    // Command done always closes the results of its transaction.
    `TKZ_ASSERT_NOW(a_done_is_last, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tuser == tkz_pkg::K_DONE, m_axis_tlast)

    // A request for more input stands alone.
    `TKZ_ASSERT_NOW(a_more_alone, i_clk, i_rst_n,
        w_load && w_res[0].kind == tkz_pkg::K_MORE, w_cnt == 2'd1)

    // A finished command leaves the lexer in its reset state.
    `TKZ_ASSERT_NEXT(a_done_clears, i_clk, i_rst_n,
        w_adv && r_in_cmd && w_res[0].kind != tkz_pkg::K_MORE,
        r_count == '0 && !r_arg_open && r_lex == tkz_pkg::LX_TEXT)

endmodule
